@@ hw/rtl/dagrc_pkg.sv @@
// Shared types, constants and helpers for the reachability closure block.
package dagrc_pkg;

  localparam int MAX_NODES   = 64;
  localparam int ROW_W       = 64;
  localparam int NODE_W      = 6;
  localparam int CNT_W       = 7;
  localparam int NODE_AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REJECT,
    OP_READ,
    OP_RANGE,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [ROW_W-1:0]  mask;
  } qentry_t;

  typedef struct packed {
    logic    empty;
    qentry_t head;
  } qstat_t;

  // Ones in every bit below the node count.
  function automatic logic [ROW_W-1:0] count_mask(input logic [CNT_W-1:0] c);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CNT_W'(j) < c);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/dagrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dagrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/dagrc_queue.sv @@
// Short FIFO between the classifying front end and the executing back end.
module dagrc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dagrc_pkg::qentry_t push_entry,
  output logic               full,
  input  logic               pop,
  output dagrc_pkg::qstat_t  stat
);
  import dagrc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = slot_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/dagrc_front.sv @@
// Front end: node count register, APB access, item acceptance and classification.
module dagrc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dagrc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dagrc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dagrc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [dagrc_pkg::NODE_W-1:0]   in_source_node,
  input  logic [dagrc_pkg::NODE_W-1:0]   in_successor_node,
  input  logic                           q_full,
  output logic                           q_push,
  output dagrc_pkg::qentry_t             q_entry
);
  import dagrc_pkg::*;

  logic [CNT_W-1:0] node_count_r, node_count_nxt;
  logic [CNT_W-1:0] cnt_eff;
  logic             reg_hit;
  logic             src_bad, dst_bad;
  op_t              op;

  assign reg_hit    = (cfg_paddr[2] == REG_NODE_COUNT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? CFG_DW'(node_count_r) : '0;

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      node_count_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  // Clamp the count into one to the table size.
  always_comb begin
    if (node_count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      cnt_eff = CNT_W'(MAX_NODES);
    end else begin
      cnt_eff = node_count_r;
    end
  end

  assign src_bad = ({1'b0, in_source_node} >= cnt_eff);
  assign dst_bad = ({1'b0, in_successor_node} >= cnt_eff);

  always_comb begin
    case (in_mode)
      MODE_ADD: begin
        if (src_bad || dst_bad) begin
          op = OP_RANGE;
        end else if (in_successor_node >= in_source_node) begin
          op = OP_REJECT;
        end else begin
          op = OP_ADD;
        end
      end
      MODE_READ:  op = src_bad ? OP_RANGE : OP_READ;
      MODE_CLEAR: op = OP_CLEAR;
      default:    op = OP_NONE;
    endcase
  end

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_entry.op    = op;
  assign q_entry.src   = in_source_node;
  assign q_entry.dst   = in_successor_node;
  assign q_entry.mask  = count_mask(cnt_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

endmodule

@@ hw/rtl/dagrc_back.sv @@
// Back end: row table, written flags and result register.
module dagrc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dagrc_pkg::qstat_t             q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dagrc_pkg::ROW_W-1:0]   out_reach_row,
  output logic                          out_order_error
);
  import dagrc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_DST,
    ST_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  qentry_t              item_r, item_nxt;
  logic [ROW_W-1:0]     row_a_r, row_a_nxt;
  logic [MAX_NODES-1:0] written_r, written_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]     out_row_r, out_row_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 ram_we, ram_re;
  logic [NODE_AW-1:0]   ram_raddr;
  logic [ROW_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]     row_src, row_dst, row_new;
  logic [NODE_AW-1:0]   src_a, dst_a;
  logic                 slot_free, fire;

  assign src_a     = item_r.src[NODE_AW-1:0];
  assign dst_a     = item_r.dst[NODE_AW-1:0];
  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = (state_r == ST_FINISH) && slot_free;
  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;

  // An unwritten row holds only its own bit.
  assign row_src = written_r[src_a] ? row_a_r   : (ROW_W'(1) << item_r.src);
  assign row_dst = written_r[dst_a] ? ram_rdata : (ROW_W'(1) << item_r.dst);
  assign row_new = (row_src | row_dst) & item_r.mask;

  assign ram_we = fire && (item_r.op == OP_ADD);

  dagrc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (src_a),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_a_nxt     = row_a_r;
    written_nxt   = written_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_err_nxt   = out_err_r;
    ram_re        = 1'b0;
    ram_raddr     = src_a;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          item_nxt  = q_stat.head;
          ram_re    = 1'b1;
          ram_raddr = q_stat.head.src[NODE_AW-1:0];
          state_nxt = ST_RD_DST;
        end
      end
      ST_RD_DST: begin
        row_a_nxt = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = dst_a;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = '0;
          out_err_nxt   = 1'b0;
          case (item_r.op)
            OP_ADD: begin
              out_row_nxt        = row_new;
              written_nxt[src_a] = 1'b1;
            end
            OP_REJECT: begin
              out_row_nxt = row_src & item_r.mask;
              out_err_nxt = 1'b1;
            end
            OP_READ:  out_row_nxt = row_src & item_r.mask;
            OP_RANGE: out_err_nxt = 1'b1;
            OP_CLEAR: written_nxt = '0;
            default:  out_row_nxt = '0;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r    <= item_nxt;
    row_a_r   <= row_a_nxt;
    out_row_r <= out_row_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reach_row   = out_row_r;
  assign out_order_error = out_err_r;

endmodule

@@ hw/rtl/dag_reachability_closure.sv @@
// Top level of the reachability closure block: front end, queue and back end.
//
// Usage: the in_ channel carries one command item per handshake (in_valid high
// and in_stall low at a rising edge): add edge, read row, or clear all rows.
// Every accepted item yields exactly one out_ item with an error flag and the
// masked reachability row of the source node, or all zeros for clear,
// out-of-range and unused-mode items. The node count register is set over the
// APB-style cfg_ port (register 0 at byte address 0) while idle. An accepted
// item waits in the queue; the back end takes one item at a time through steps
// set by its single read port on the row RAM (source row read, successor row
// read, then write and result). The two-entry queue keeps taking items meanwhile.
// Reset: all rows read as unwritten (only their own bit), the node count
// returns to 64, the queue empties and no result is pending. No clearing pass.
// A stalled receiver holds the result register; the back end waits with the
// next result ready, and once the queue fills, in_stall rises.
module dag_reachability_closure (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dagrc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dagrc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dagrc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [dagrc_pkg::NODE_W-1:0]   in_source_node,
  input  logic [dagrc_pkg::NODE_W-1:0]   in_successor_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dagrc_pkg::ROW_W-1:0]    out_reach_row,
  output logic                           out_order_error
);
  import dagrc_pkg::*;

  // Front to queue: classified item with its count mask.
  logic    q_push, q_full, q_pop;
  qentry_t q_entry;
  qstat_t  q_stat;

  dagrc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_source_node    (in_source_node),
    .in_successor_node (in_successor_node),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  // Decouple acceptance from execution.
  dagrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .stat       (q_stat)
  );

  // Execute against the row table and drive the result register.
  dagrc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reach_row   (out_reach_row),
    .out_order_error (out_order_error)
  );

endmodule
